// ----- src/i2cadc_pkg.sv -----
// Package with the event codes, register roles and result word type of the I2C slave register bank.
package i2cadc_pkg;

  localparam int NUM_REGS_DEFAULT = 7;
  localparam int NUM_BASE = 7;
  localparam int BASE_AW = 3;

  localparam logic [7:0] R_CHAN   = 8'd0;
  localparam logic [7:0] R_ADC_HI = 8'd1;
  localparam logic [7:0] R_ADC_LO = 8'd2;
  localparam logic [7:0] R_DIR    = 8'd3;
  localparam logic [7:0] R_OUT    = 8'd4;
  localparam logic [7:0] R_IN     = 8'd5;
  localparam logic [7:0] R_PUE    = 8'd6;

  typedef enum logic [1:0] {
    FUNC_ADDR = 2'd0,
    FUNC_XFER = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef struct packed {
    logic       tx_load;
    logic [7:0] tx_data;
    logic       send_nack;
    logic       transmit_mode;
    logic       adc_channel;
    logic [7:0] port_direction;
    logic [7:0] port_output;
    logic [7:0] port_pullup;
  } result_t;

endpackage

// ----- src/i2cadc_ext_mem.sv -----
// Storage for the registers above the fixed bank, with per-entry valid bits and a registered read.
module i2cadc_ext_mem #(
  parameter int DEPTH = 1,
  parameter int AW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic       valid [DEPTH];
  logic [7:0] rd_q;
  logic       rd_valid;
  logic       wr_ok;
  logic       rd_ok;
  logic       bypass;

  assign wr_ok  = wr_en && (32'(wr_addr) < DEPTH);
  assign rd_ok  = 32'(rd_addr) < DEPTH;
  assign bypass = wr_ok && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
    if (bypass) begin
      rd_q <= wr_data;
    end else if (rd_ok) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        valid[i] <= 1'b0;
      end
      rd_valid <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= bypass || (rd_ok && valid[rd_addr]);
    end
  end

  assign rd_data = rd_valid ? rd_q : 8'd0;

endmodule

// ----- src/i2c_slave_adc_io_register_bank.sv -----
// Top level of the I2C slave register bank for the ADC bridge and I/O expander.
// Each event word is taken and its result word is registered.
// Throughput is one word per cycle; a two-entry output stage keeps the input open while
// a result is held by a stalled receiver, and the input stalls only when both entries are full.
// Synchronous reset clears all registers, the pointer, the flags and the valid bits of the
// upper register storage at once, so an event may be taken in the cycle after reset.
module i2c_slave_adc_io_register_bank #(
  parameter int NUM_REGS = i2cadc_pkg::NUM_REGS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic       read_request,
  input  logic [7:0] rx_byte,
  input  logic       master_nack,
  input  logic       adc_ready,
  input  logic [9:0] adc_result,
  input  logic [7:0] port_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_load,
  output logic [7:0] tx_data,
  output logic       send_nack,
  output logic       transmit_mode,
  output logic       adc_channel,
  output logic [7:0] port_direction,
  output logic [7:0] port_output,
  output logic [7:0] port_pullup
);

  localparam int EXT_DEPTH = (NUM_REGS > i2cadc_pkg::NUM_BASE) ?
                             (NUM_REGS - i2cadc_pkg::NUM_BASE) : 1;
  localparam int EXT_AW = (EXT_DEPTH > 1) ? $clog2(EXT_DEPTH) : 1;
  localparam logic [7:0] NREG8 = 8'(NUM_REGS);
  localparam logic [7:0] NBASE8 = 8'(i2cadc_pkg::NUM_BASE);

  logic [7:0] base [i2cadc_pkg::NUM_BASE];
  logic [7:0] base_next [i2cadc_pkg::NUM_BASE];
  logic [7:0] reg_pointer, reg_pointer_next;
  logic       past_first_byte, past_first_byte_next;
  logic       adc_lock, adc_lock_next;
  logic       tx_mode_flag, tx_mode_flag_next;
  logic       channel_select, channel_select_next;
  logic       nack_setting, nack_setting_next;

  logic              accept;
  logic              take;
  logic              in_base;
  logic              in_ext;
  logic [7:0]        sel_data;
  logic [7:0]        ext_rd_data;
  logic              ext_wr_en;
  logic [7:0]        ext_off;
  logic [7:0]        ext_off_next;
  logic              load;
  logic [7:0]        data;
  i2cadc_pkg::result_t res;
  i2cadc_pkg::result_t out_q;
  i2cadc_pkg::result_t skid_q;
  logic              skid_valid;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;

  assign in_base      = reg_pointer < NBASE8;
  assign in_ext       = !in_base && (reg_pointer < NREG8);
  assign ext_off      = reg_pointer - NBASE8;
  assign ext_off_next = reg_pointer_next - NBASE8;

  always_comb begin
    if (in_base) begin
      sel_data = base[reg_pointer[i2cadc_pkg::BASE_AW-1:0]];
    end else if (in_ext) begin
      sel_data = ext_rd_data;
    end else begin
      sel_data = 8'd0;
    end
  end

  always_comb begin
    for (int i = 0; i < i2cadc_pkg::NUM_BASE; i++) begin
      base_next[i] = base[i];
    end
    reg_pointer_next     = reg_pointer;
    past_first_byte_next = past_first_byte;
    adc_lock_next        = adc_lock;
    tx_mode_flag_next    = tx_mode_flag;
    channel_select_next  = channel_select;
    nack_setting_next    = nack_setting;
    ext_wr_en            = 1'b0;
    load                 = 1'b0;
    data                 = 8'd0;
    if (accept) begin
      unique case (i2cadc_pkg::func_t'(func))
        i2cadc_pkg::FUNC_ADDR: begin
          if (read_request) begin
            tx_mode_flag_next = 1'b1;
            load = 1'b1;
            data = sel_data;
            if (reg_pointer == i2cadc_pkg::R_ADC_HI) begin
              adc_lock_next = 1'b1;
            end
            if (reg_pointer == i2cadc_pkg::R_ADC_LO) begin
              adc_lock_next = 1'b0;
            end
          end else begin
            tx_mode_flag_next = 1'b0;
            past_first_byte_next = 1'b0;
          end
        end
        i2cadc_pkg::FUNC_XFER: begin
          if (tx_mode_flag) begin
            if (master_nack) begin
              tx_mode_flag_next = 1'b0;
            end else begin
              load = 1'b1;
              data = sel_data;
            end
          end else if (!past_first_byte) begin
            nack_setting_next = 1'b0;
            reg_pointer_next = rx_byte;
            past_first_byte_next = 1'b1;
          end else begin
            nack_setting_next = 1'b1;
            if (in_base) begin
              base_next[reg_pointer[i2cadc_pkg::BASE_AW-1:0]] = rx_byte;
              if (reg_pointer == i2cadc_pkg::R_CHAN) begin
                channel_select_next = rx_byte != 8'd0;
              end
            end else if (in_ext) begin
              ext_wr_en = 1'b1;
            end
          end
        end
        i2cadc_pkg::FUNC_TICK: begin
          if (adc_ready && !adc_lock) begin
            base_next[i2cadc_pkg::R_ADC_HI[i2cadc_pkg::BASE_AW-1:0]] =
              {6'd0, adc_result[9:8]};
            base_next[i2cadc_pkg::R_ADC_LO[i2cadc_pkg::BASE_AW-1:0]] = adc_result[7:0];
          end
          base_next[i2cadc_pkg::R_IN[i2cadc_pkg::BASE_AW-1:0]] = port_in;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.tx_load        = load;
    res.tx_data        = data;
    res.send_nack      = nack_setting_next;
    res.transmit_mode  = tx_mode_flag_next;
    res.adc_channel    = channel_select_next;
    res.port_direction = base_next[i2cadc_pkg::R_DIR[i2cadc_pkg::BASE_AW-1:0]];
    res.port_output    = base_next[i2cadc_pkg::R_OUT[i2cadc_pkg::BASE_AW-1:0]];
    res.port_pullup    = base_next[i2cadc_pkg::R_PUE[i2cadc_pkg::BASE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < i2cadc_pkg::NUM_BASE; i++) begin
        base[i] <= 8'd0;
      end
      reg_pointer     <= 8'd0;
      past_first_byte <= 1'b0;
      adc_lock        <= 1'b0;
      tx_mode_flag    <= 1'b0;
      channel_select  <= 1'b0;
      nack_setting    <= 1'b0;
    end else begin
      for (int i = 0; i < i2cadc_pkg::NUM_BASE; i++) begin
        base[i] <= base_next[i];
      end
      reg_pointer     <= reg_pointer_next;
      past_first_byte <= past_first_byte_next;
      adc_lock        <= adc_lock_next;
      tx_mode_flag    <= tx_mode_flag_next;
      channel_select  <= channel_select_next;
      nack_setting    <= nack_setting_next;
    end
  end

  i2cadc_ext_mem #(
    .DEPTH(EXT_DEPTH),
    .AW(EXT_AW)
  ) u_ext_mem (
    .clk(clk),
    .rst(rst),
    .wr_en(ext_wr_en),
    .wr_addr(ext_off[EXT_AW-1:0]),
    .wr_data(rx_byte),
    .rd_addr(ext_off_next[EXT_AW-1:0]),
    .rd_data(ext_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!accept) begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      if (!out_valid) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign tx_load        = out_q.tx_load;
  assign tx_data        = out_q.tx_data;
  assign send_nack      = out_q.send_nack;
  assign transmit_mode  = out_q.transmit_mode;
  assign adc_channel    = out_q.adc_channel;
  assign port_direction = out_q.port_direction;
  assign port_output    = out_q.port_output;
  assign port_pullup    = out_q.port_pullup;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid entry held without an output word.");

  a_read_sets_tx: assert property (@(posedge clk) disable iff (rst)
    (accept && func == i2cadc_pkg::FUNC_ADDR && read_request) |=> tx_mode_flag)
    else $error("Addressed read did not enter transmit mode.");

  a_data_byte_nacked: assert property (@(posedge clk) disable iff (rst)
    (accept && func == i2cadc_pkg::FUNC_XFER && !tx_mode_flag && past_first_byte)
    |=> nack_setting)
    else $error("Data byte after the pointer byte was not NACKed.");

  a_channel_matches: assert property (@(posedge clk) disable iff (rst)
    channel_select == (base[i2cadc_pkg::R_CHAN[i2cadc_pkg::BASE_AW-1:0]] != 8'd0))
    else $error("Channel select disagrees with the channel register.");

endmodule

// ----- tb/sv/i2c_slave_adc_io_register_bank_tb.sv -----
// Self-checking testbench for the I2C slave ADC and I/O register bank.
`timescale 1ns / 100ps

module i2c_slave_adc_io_register_bank_tb;

  localparam int BANK_DEPTH = i2cadc_pkg::NUM_REGS_DEFAULT;
  localparam int RANDOM_EVENTS = 1250;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    i2cadc_pkg::func_t func;
    logic       read_request;
    logic [7:0] rx_byte;
    logic       master_nack;
    logic       adc_ready;
    logic [9:0] adc_result;
    logic [7:0] port_in;
  } bus_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] func = i2cadc_pkg::FUNC_NONE;
  logic       read_request = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       master_nack = 1'b0;
  logic       adc_ready = 1'b0;
  logic [9:0] adc_result = 10'h000;
  logic [7:0] port_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       tx_load;
  logic [7:0] tx_data;
  logic       send_nack;
  logic       transmit_mode;
  logic       adc_channel;
  logic [7:0] port_direction;
  logic [7:0] port_output;
  logic [7:0] port_pullup;

  bus_event_t pending_events[$];
  i2cadc_pkg::result_t expected_results[$];
  bus_event_t driven_event;
  int         total_events = 0;
  int         accepted_count = 0;
  int         error_count = 0;
  int         cycle_count = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;

  // Shadow copy of the slave's registers and flags.
  logic [7:0] bank [BANK_DEPTH];
  logic [7:0] reg_ptr;
  logic       past_first;
  logic       adc_lock;
  logic       tx_mode;
  logic       chan_sel;
  logic       nack_set;

  i2c_slave_adc_io_register_bank #(
    .NUM_REGS(BANK_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .read_request(read_request),
    .rx_byte(rx_byte),
    .master_nack(master_nack),
    .adc_ready(adc_ready),
    .adc_result(adc_result),
    .port_in(port_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tx_load(tx_load),
    .tx_data(tx_data),
    .send_nack(send_nack),
    .transmit_mode(transmit_mode),
    .adc_channel(adc_channel),
    .port_direction(port_direction),
    .port_output(port_output),
    .port_pullup(port_pullup)
  );

  always #4 clk = ~clk;

  task automatic apply_bus_event(input bus_event_t ev, output i2cadc_pkg::result_t res);
    logic [7:0] selected;
    res = '0;
    selected = (reg_ptr < BANK_DEPTH) ? bank[reg_ptr] : 8'h00;
    case (ev.func)
      i2cadc_pkg::FUNC_ADDR: begin
        if (ev.read_request) begin
          tx_mode = 1'b1;
          res.tx_load = 1'b1;
          res.tx_data = selected;
          if (reg_ptr == i2cadc_pkg::R_ADC_HI) adc_lock = 1'b1;
          if (reg_ptr == i2cadc_pkg::R_ADC_LO) adc_lock = 1'b0;
        end else begin
          tx_mode = 1'b0;
          past_first = 1'b0;
        end
      end
      i2cadc_pkg::FUNC_XFER: begin
        if (tx_mode) begin
          if (ev.master_nack) begin
            tx_mode = 1'b0;
          end else begin
            res.tx_load = 1'b1;
            res.tx_data = selected;
          end
        end else if (!past_first) begin
          nack_set = 1'b0;
          reg_ptr = ev.rx_byte;
          past_first = 1'b1;
        end else begin
          nack_set = 1'b1;
          if (reg_ptr < BANK_DEPTH) begin
            bank[reg_ptr] = ev.rx_byte;
            if (reg_ptr == i2cadc_pkg::R_CHAN) chan_sel = (ev.rx_byte != 8'h00);
          end
        end
      end
      i2cadc_pkg::FUNC_TICK: begin
        if (ev.adc_ready && !adc_lock) begin
          bank[i2cadc_pkg::R_ADC_HI] = {6'b000000, ev.adc_result[9:8]};
          bank[i2cadc_pkg::R_ADC_LO] = ev.adc_result[7:0];
        end
        bank[i2cadc_pkg::R_IN] = ev.port_in;
      end
      default: begin
      end
    endcase
    res.send_nack = nack_set;
    res.transmit_mode = tx_mode;
    res.adc_channel = chan_sel;
    res.port_direction = bank[i2cadc_pkg::R_DIR];
    res.port_output = bank[i2cadc_pkg::R_OUT];
    res.port_pullup = bank[i2cadc_pkg::R_PUE];
  endtask

  function automatic bus_event_t random_event();
    bus_event_t ev;
    ev.func = i2cadc_pkg::func_t'($urandom_range(3));
    ev.read_request = 1'($urandom_range(1));
    ev.rx_byte = 8'($urandom_range(255));
    ev.master_nack = 1'($urandom_range(1));
    ev.adc_ready = 1'($urandom_range(1));
    ev.adc_result = 10'($urandom_range(1023));
    ev.port_in = 8'($urandom_range(255));
    return ev;
  endfunction

  task automatic bus_addr(input logic rd);
    bus_event_t ev;
    ev = random_event();
    ev.func = i2cadc_pkg::FUNC_ADDR;
    ev.read_request = rd;
    pending_events.push_back(ev);
  endtask

  task automatic bus_xfer(input logic [7:0] rx, input logic nack);
    bus_event_t ev;
    ev = random_event();
    ev.func = i2cadc_pkg::FUNC_XFER;
    ev.rx_byte = rx;
    ev.master_nack = nack;
    pending_events.push_back(ev);
  endtask

  task automatic bus_tick(input logic rdy, input logic [9:0] conv, input logic [7:0] pins);
    bus_event_t ev;
    ev = random_event();
    ev.func = i2cadc_pkg::FUNC_TICK;
    ev.adc_ready = rdy;
    ev.adc_result = conv;
    ev.port_in = pins;
    pending_events.push_back(ev);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  function automatic int send_idle_pct();
    if (accepted_count < total_events / 3) return 17;
    if (accepted_count < 2 * total_events / 3) return 70;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted_count < total_events / 3) return 70;
    if (accepted_count < 2 * total_events / 3) return 17;
    return 0;
  endfunction

  always @(posedge clk) begin : drive_events
    i2cadc_pkg::result_t predicted;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_bus_event(driven_event, predicted);
        expected_results.push_back(predicted);
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          driven_event = pending_events.pop_front();
          func <= driven_event.func;
          read_request <= driven_event.read_request;
          rx_byte <= driven_event.rx_byte;
          master_nack <= driven_event.master_nack;
          adc_ready <= driven_event.adc_ready;
          adc_result <= driven_event.adc_result;
          port_in <= driven_event.port_in;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver holds off for a long stretch once, late in the run with the sender flat out.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_count >= 5 * total_events / 6) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    i2cadc_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, got %0h", $time,
                   {tx_load, tx_data, send_nack, transmit_mode, adc_channel,
                    port_direction, port_output, port_pullup});
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("tx_load", 8'(want.tx_load), 8'(tx_load));
          check_field("tx_data", want.tx_data, tx_data);
          check_field("send_nack", 8'(want.send_nack), 8'(send_nack));
          check_field("transmit_mode", 8'(want.transmit_mode), 8'(transmit_mode));
          check_field("adc_channel", 8'(want.adc_channel), 8'(adc_channel));
          check_field("port_direction", want.port_direction, port_direction);
          check_field("port_output", want.port_output, port_output);
          check_field("port_pullup", want.port_pullup, port_pullup);
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int directed_count;
    int pick;
    logic [7:0] ptr;

    foreach (bank[i]) bank[i] = 8'h00;
    reg_ptr = 8'h00;
    past_first = 1'b0;
    adc_lock = 1'b0;
    tx_mode = 1'b0;
    chan_sel = 1'b0;
    nack_set = 1'b0;

    bus_tick(1'b1, 10'h3FF, 8'hFF);
    bus_tick(1'b1, 10'h000, 8'h00);
    bus_addr(1'b1);
    bus_xfer(8'h00, 1'b0);
    bus_xfer(8'h00, 1'b1);
    bus_addr(1'b0);
    bus_xfer(i2cadc_pkg::R_CHAN, 1'b0);
    bus_xfer(8'hFF, 1'b0);
    bus_xfer(8'h00, 1'b0);
    bus_xfer(8'h80, 1'b0);
    bus_addr(1'b0);
    bus_xfer(i2cadc_pkg::R_DIR, 1'b0);
    bus_xfer(8'hA5, 1'b0);
    bus_addr(1'b0);
    bus_xfer(i2cadc_pkg::R_PUE, 1'b0);
    bus_xfer(8'h5A, 1'b0);
    // A read starting at the ADC high byte locks it against ticks until one starts at the low byte.
    bus_addr(1'b0);
    bus_xfer(i2cadc_pkg::R_ADC_HI, 1'b0);
    bus_addr(1'b1);
    bus_xfer(8'h00, 1'b1);
    bus_tick(1'b1, 10'h2AA, 8'h55);
    bus_addr(1'b0);
    bus_xfer(i2cadc_pkg::R_ADC_LO, 1'b0);
    bus_addr(1'b1);
    bus_xfer(8'h00, 1'b1);
    bus_tick(1'b1, 10'h155, 8'hAA);
    bus_addr(1'b0);
    bus_xfer(8'hFF, 1'b0);
    bus_xfer(8'h12, 1'b0);
    bus_addr(1'b1);
    bus_xfer(8'h00, 1'b1);
    pending_events.push_back('{i2cadc_pkg::FUNC_NONE, 1'b1, 8'hFF, 1'b1, 1'b1, 10'h3FF, 8'hFF});
    directed_count = pending_events.size();

    while (pending_events.size() < directed_count + RANDOM_EVENTS) begin
      pick = $urandom_range(99);
      ptr = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
      if (pick < 35) begin
        bus_addr(1'b0);
        bus_xfer(ptr, 1'($urandom_range(1)));
        repeat ($urandom_range(3))
          bus_xfer(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      end else if (pick < 65) begin
        bus_addr(1'b0);
        bus_xfer(ptr, 1'($urandom_range(1)));
        bus_addr(1'b1);
        repeat ($urandom_range(3)) bus_xfer(8'($urandom_range(255)), 1'b0);
        bus_xfer(8'($urandom_range(255)), 1'b1);
      end else if (pick < 90) begin
        bus_tick(1'($urandom_range(1)), 10'($urandom_range(1023)), 8'($urandom_range(255)));
      end else begin
        pending_events.push_back(random_event());
      end
    end
    total_events = pending_events.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
